@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the interpolation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: clocked property violated");
// Condition that must never be true at a clock edge
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ rtl/btli_pkg.sv @@
// Shared types and constants of the breakpoint table interpolation unit
package btli_pkg;

   localparam int TIME_W   = 32;
   localparam int FLOW_W   = 32;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int REGION_W = 2;
   localparam int PROD_W   = 2 * TIME_W;
   localparam int ITER_W   = 6;
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 64;

   typedef enum logic [1:0] {
      REG_INTERIOR = 2'd0,
      REG_FIRST    = 2'd1,
      REG_PAST_END = 2'd2,
      REG_EMPTY    = 2'd3
   } region_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_START,
      CMD_SCAN,
      CMD_MUL_INIT,
      CMD_MUL,
      CMD_DIV_INIT,
      CMD_DIV,
      CMD_FINISH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      region_type region;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic empty;
      logic past_end;
      logic found;
      logic first;
      logic iter_last;
   } dp_status_type;

endpackage

@@ rtl/breakpoint_table_linear_interp_unit.sv @@
// Top level of the breakpoint table piecewise linear interpolation unit
//
// Request channel (req_*): one item per handshake, accepted when req_valid is
// high and req_stall is low. req_action 0 loads one (time, flow) breakpoint at
// req_entry_index and returns nothing; indexes at or past MAX_POINTS are
// dropped. req_action 1 queries the flow at req_query_time and returns one item.
// A query scans the cnt points in use, one entry per cycle through the single
// read port, then passes a decide and a finish state before its result is
// registered. An interior segment adds 32 shift-add multiply steps, one divide
// setup step and 64 restoring divide steps before the finish state. The request
// side stays stalled until the result is registered, so a new item is taken
// only after the last query is through.
// Response channel (rsp_*): a result sits in an output register until taken
// (rsp_valid high, rsp_stall low); a new item is accepted while it waits, and
// a later query only waits at its finish cycle if the register is still full.
// Config (csr_*): point_count is written whenever csr_valid is high; csr_ready
// is always high. Write it only while the block is idle.
// Reset (synchronous, active high) clears point_count and the control state;
// the breakpoint memory is not cleared and must be loaded before queries.
module breakpoint_table_linear_interp_unit #(
   parameter int MAX_POINTS = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [btli_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [btli_pkg::TIME_W-1:0]        req_entry_time,
   input  logic signed [btli_pkg::FLOW_W-1:0] req_entry_flow,
   input  logic [btli_pkg::TIME_W-1:0]        req_query_time,
   input  logic                               req_first_step,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [btli_pkg::FLOW_W-1:0] rsp_flow_value,
   output logic [btli_pkg::REGION_W-1:0]      rsp_region,
   output logic [btli_pkg::INDEX_W-1:0]       rsp_segment_index,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [btli_pkg::COUNT_W-1:0]       csr_point_count
);
   import btli_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // config register has no back-pressure
   assign csr_ready = 1'b1;

   btli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   btli_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_entry_index   (req_entry_index),
      .req_entry_time    (req_entry_time),
      .req_entry_flow    (req_entry_flow),
      .req_query_time    (req_query_time),
      .req_first_step    (req_first_step),
      .csr_write         (csr_valid && csr_ready),
      .csr_point_count   (csr_point_count),
      .rsp_flow_value    (rsp_flow_value),
      .rsp_region        (rsp_region),
      .rsp_segment_index (rsp_segment_index)
   );

endmodule

@@ rtl/btli_dp.sv @@
// Datapath: breakpoint memory, segment scan, shift-add multiply, restoring divide
`include "assert_macros.svh"
module btli_dp #(
   parameter int MAX_POINTS = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  btli_pkg::dp_cmd_type              cmd,
   output btli_pkg::dp_status_type           status,
   input  logic [btli_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic [btli_pkg::TIME_W-1:0]       req_entry_time,
   input  logic signed [btli_pkg::FLOW_W-1:0] req_entry_flow,
   input  logic [btli_pkg::TIME_W-1:0]       req_query_time,
   input  logic                              req_first_step,
   input  logic                              csr_write,
   input  logic [btli_pkg::COUNT_W-1:0]      csr_point_count,
   output logic signed [btli_pkg::FLOW_W-1:0] rsp_flow_value,
   output logic [btli_pkg::REGION_W-1:0]     rsp_region,
   output logic [btli_pkg::INDEX_W-1:0]      rsp_segment_index
);
   import btli_pkg::*;

   localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int SW    = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam int AW    = SW + 1;
   localparam int ENT_W = TIME_W + FLOW_W;

   // entry memory: time in the upper half, flow in the lower half
   logic [ENT_W-1:0] entry_mem [MAX_POINTS];
   logic [ENT_W-1:0] rd_data_ff;

   logic [COUNT_W-1:0] point_count_ff;
   logic [CNT_W-1:0]   cnt;
   logic [CMP_W-1:0]   pc_ext;
   logic [AW-1:0]      wr_ext;
   logic               wr_en;
   logic               issue;
   logic [TIME_W-1:0]  cur_t;
   logic [FLOW_W-1:0]  cur_f;

   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic               dvld_ff, dvld_in;
   logic [IDX_W-1:0]   didx_ff, didx_in;
   logic [TIME_W-1:0]  qt_ff, qt_in;
   logic               first_ff, first_in;
   logic [TIME_W-1:0]  last_t_ff, last_t_in;
   logic [FLOW_W-1:0]  last_f_ff, last_f_in;
   logic [FLOW_W-1:0]  first_f_ff, first_f_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   seg_ff, seg_in;
   logic [TIME_W-1:0]  t0_ff, t0_in;
   logic [TIME_W-1:0]  t1_ff, t1_in;
   logic [FLOW_W-1:0]  f0_ff, f0_in;
   logic [FLOW_W-1:0]  f1_ff, f1_in;
   logic [TIME_W-1:0]  mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [TIME_W-1:0]  dx_ff, dx_in;
   logic [TIME_W-1:0]  dt_ff, dt_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TIME_W-1:0]  rem_ff, rem_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;
   logic [FLOW_W-1:0]  out_flow_ff, out_flow_in;
   logic [REGION_W-1:0] out_region_ff, out_region_in;
   logic [INDEX_W-1:0] out_seg_ff, out_seg_in;

   assign pc_ext = CMP_W'(point_count_ff);
   assign cnt    = (pc_ext > CMP_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                  : CNT_W'(point_count_ff);
   assign wr_ext = AW'(req_entry_index);
   assign wr_en  = (cmd.op == CMD_LOAD) && (wr_ext < AW'(MAX_POINTS));
   assign issue  = (addr_ff < cnt);
   assign cur_t  = rd_data_ff[ENT_W-1:FLOW_W];
   assign cur_f  = rd_data_ff[FLOW_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_ext[IDX_W-1:0]] <= {req_entry_time, req_entry_flow};
      end
      rd_data_ff <= entry_mem[addr_ff[IDX_W-1:0]];
   end

   always_comb begin
      logic [FLOW_W:0]     df;
      logic [FLOW_W:0]     df_abs;
      logic [TIME_W:0]     trial;
      logic [FLOW_W+1:0]   sum;
      logic [SW-1:0]       seg_ext;

      df      = '0;
      df_abs  = '0;
      trial   = '0;
      sum     = '0;
      seg_ext = SW'(seg_ff);

      addr_in       = addr_ff;
      dvld_in       = (cmd.op == CMD_SCAN) && issue;
      didx_in       = addr_ff[IDX_W-1:0];
      qt_in         = qt_ff;
      first_in      = first_ff;
      last_t_in     = last_t_ff;
      last_f_in     = last_f_ff;
      first_f_in    = first_f_ff;
      found_in      = found_ff;
      seg_in        = seg_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      f0_in         = f0_ff;
      f1_in         = f1_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      dx_in         = dx_ff;
      dt_in         = dt_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      iter_in       = iter_ff;
      out_flow_in   = out_flow_ff;
      out_region_in = out_region_ff;
      out_seg_in    = out_seg_ff;

      unique case (cmd.op)
         CMD_NOP, CMD_LOAD: begin
         end
         CMD_START: begin
            qt_in    = req_query_time;
            first_in = req_first_step;
            addr_in  = '0;
            found_in = 1'b0;
         end
         CMD_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            if (dvld_ff) begin
               last_t_in = cur_t;
               last_f_in = cur_f;
               if (didx_ff == '0) begin
                  first_f_in = cur_f;
               end else if (qt_ff >= last_t_ff && qt_ff < cur_t) begin
                  // later matches overwrite: highest segment wins
                  found_in = 1'b1;
                  seg_in   = didx_ff - 1'b1;
                  t0_in    = last_t_ff;
                  f0_in    = last_f_ff;
                  t1_in    = cur_t;
                  f1_in    = cur_f;
               end
            end
         end
         CMD_MUL_INIT: begin
            df      = {f1_ff[FLOW_W-1], f1_ff} - {f0_ff[FLOW_W-1], f0_ff};
            df_abs  = df[FLOW_W] ? (~df + 1'b1) : df;
            neg_in  = df[FLOW_W];
            mag_in  = df_abs[FLOW_W-1:0];
            dx_in   = qt_ff - t0_ff;
            dt_in   = t1_ff - t0_ff;
            prod_in = '0;
            iter_in = ITER_W'(MUL_STEPS - 1);
         end
         CMD_MUL: begin
            // MSB-first shift-add over the bits of dx
            prod_in = {prod_ff[PROD_W-2:0], 1'b0}
                    + (dx_ff[TIME_W-1] ? PROD_W'(mag_ff) : '0);
            dx_in   = {dx_ff[TIME_W-2:0], 1'b0};
            iter_in = iter_ff - 1'b1;
         end
         CMD_DIV_INIT: begin
            rem_in  = '0;
            iter_in = ITER_W'(DIV_STEPS - 1);
         end
         CMD_DIV: begin
            // restoring divide; quotient bits shift into prod from the right
            trial = {rem_ff, prod_ff[PROD_W-1]};
            if (trial >= {1'b0, dt_ff}) begin
               rem_in  = TIME_W'(trial - {1'b0, dt_ff});
               prod_in = {prod_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[TIME_W-1:0];
               prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
         end
         CMD_FINISH: begin
            out_region_in = cmd.region;
            out_seg_in    = '0;
            unique case (cmd.region)
               REG_INTERIOR: begin
                  sum = neg_ff ? ({{2{f0_ff[FLOW_W-1]}}, f0_ff}
                                  - {2'b00, prod_ff[TIME_W-1:0]})
                               : ({{2{f0_ff[FLOW_W-1]}}, f0_ff}
                                  + {2'b00, prod_ff[TIME_W-1:0]});
                  if (sum[FLOW_W+1:FLOW_W-1] == 3'b000
                      || sum[FLOW_W+1:FLOW_W-1] == 3'b111) begin
                     out_flow_in = sum[FLOW_W-1:0];
                  end else if (sum[FLOW_W+1]) begin
                     out_flow_in = {1'b1, {(FLOW_W-1){1'b0}}};
                  end else begin
                     out_flow_in = {1'b0, {(FLOW_W-1){1'b1}}};
                  end
                  out_seg_in = seg_ext[INDEX_W-1:0];
               end
               REG_FIRST:    out_flow_in = first_f_ff;
               REG_PAST_END: out_flow_in = last_f_ff;
               REG_EMPTY:    out_flow_in = '0;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         dvld_ff        <= 1'b0;
         found_ff       <= 1'b0;
         addr_ff        <= '0;
         iter_ff        <= '0;
      end else begin
         if (csr_write) begin
            point_count_ff <= csr_point_count;
         end
         dvld_ff  <= dvld_in;
         found_ff <= found_in;
         addr_ff  <= addr_in;
         iter_ff  <= iter_in;
      end
      didx_ff       <= didx_in;
      qt_ff         <= qt_in;
      first_ff      <= first_in;
      last_t_ff     <= last_t_in;
      last_f_ff     <= last_f_in;
      first_f_ff    <= first_f_in;
      seg_ff        <= seg_in;
      t0_ff         <= t0_in;
      t1_ff         <= t1_in;
      f0_ff         <= f0_in;
      f1_ff         <= f1_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      dx_ff         <= dx_in;
      dt_ff         <= dt_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      out_flow_ff   <= out_flow_in;
      out_region_ff <= out_region_in;
      out_seg_ff    <= out_seg_in;
   end

   assign status.scan_done = !issue && !dvld_ff;
   assign status.empty     = (cnt == '0);
   assign status.past_end  = (qt_ff >= last_t_ff);
   assign status.found     = found_ff;
   assign status.first     = first_ff;
   assign status.iter_last = (iter_ff == '0);

   assign rsp_flow_value    = out_flow_ff;
   assign rsp_region        = out_region_ff;
   assign rsp_segment_index = out_seg_ff;

   `ASSERT_CLK(a_seg_ordered, clock, reset, found_ff |-> (t0_ff < t1_ff))
   `ASSERT_CLK(a_rem_below_divisor, clock, reset, (cmd.op == CMD_DIV) |-> (rem_ff < dt_ff))
   `ASSERT_NEVER(a_quotient_fits, clock, reset, cmd.op == CMD_FINISH && cmd.region == REG_INTERIOR && prod_ff[PROD_W-1:TIME_W] != '0)

endmodule

@@ rtl/btli_ctrl.sv @@
// Controller state machine sequencing load, scan, multiply, divide and result
`include "assert_macros.svh"
module btli_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output btli_pkg::dp_cmd_type    cmd,
   input  btli_pkg::dp_status_type status
);
   import btli_pkg::*;

   state_type  state_ff, state_in;
   region_type region_ff, region_in;
   logic       rsp_valid_ff, rsp_valid_in;
   region_type region_sel;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // region decision once the scan is complete
   always_comb begin
      priority if (status.empty) begin
         region_sel = REG_EMPTY;
      end else if (status.past_end) begin
         region_sel = REG_PAST_END;
      end else if (status.found && !status.first) begin
         region_sel = REG_INTERIOR;
      end else begin
         region_sel = REG_FIRST;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = (region_sel == REG_INTERIOR) ? ST_MUL : ST_FINISH;
         end
         ST_MUL: begin
            if (status.iter_last) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV;
         ST_DIV: begin
            if (status.iter_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd.op       = CMD_NOP;
      cmd.region   = region_ff;
      region_in    = region_ff;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = req_action ? CMD_START : CMD_LOAD;
            end
         end
         ST_SCAN: cmd.op = CMD_SCAN;
         ST_DECIDE: begin
            region_in = region_sel;
            if (region_sel == REG_INTERIOR) begin
               cmd.op = CMD_MUL_INIT;
            end
         end
         ST_MUL:      cmd.op = CMD_MUL;
         ST_DIV_INIT: cmd.op = CMD_DIV_INIT;
         ST_DIV:      cmd.op = CMD_DIV;
         ST_FINISH: begin
            if (out_free) begin
               cmd.op       = CMD_FINISH;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         region_ff    <= REG_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
   `ASSERT_CLK(a_div_to_finish, clock, reset, (state_ff == ST_DIV && status.iter_last) |=> (state_ff == ST_FINISH))
   `ASSERT_CLK(a_empty_region, clock, reset, (state_ff == ST_DECIDE && status.empty) |=> (state_ff == ST_FINISH && region_ff == REG_EMPTY))

endmodule
